// ----- design/dtwb_pkg.sv -----
// Shared types, constants and CORDIC arctangent table for the detection box block.
package dtwb_pkg;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [1:0] MODE_MAP     = 2'd0;
  localparam logic [1:0] MODE_BASE    = 2'd1;
  localparam logic [1:0] MODE_INVALID = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  localparam logic [2:0] REG_OFS_X  = 3'd0;
  localparam logic [2:0] REG_OFS_Y  = 3'd1;
  localparam logic [2:0] REG_MODE   = 3'd2;
  localparam logic [2:0] REG_MIRROR = 3'd3;
  localparam logic [2:0] REG_ENABLE = 3'd4;
  localparam logic [2:0] REG_THRESH = 3'd5;

  function automatic logic signed [33:0] atan_turn(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd536870912;
      1: r = 34'sd316933406;
      2: r = 34'sd167458907;
      3: r = 34'sd85004756;
      4: r = 34'sd42667331;
      5: r = 34'sd21354465;
      6: r = 34'sd10679838;
      7: r = 34'sd5340245;
      8: r = 34'sd2670163;
      9: r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic               mode_map;
    logic               mode_base;
    logic signed [31:0] rob_x;
    logic signed [31:0] rob_y;
    logic        [30:0] size_x;
    logic        [30:0] size_y;
  } side_t;

endpackage

// ----- design/dtwb_cordic.sv -----
// Pipelined rotation-mode CORDIC: one stage per iteration, stall-aware.
module dtwb_cordic #(
  parameter int STAGES = 16,
  parameter int SIDE_W = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [15:0]               angle,
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_valid,
  output logic signed [31:0]        cos_q30,
  output logic signed [31:0]        sin_q30,
  output logic [SIDE_W-1:0]         out_side
);

  logic signed [33:0] x [0:STAGES];
  logic signed [33:0] y [0:STAGES];
  logic signed [33:0] z [0:STAGES];
  logic               flip [0:STAGES];
  logic               vld [0:STAGES];
  logic [SIDE_W-1:0]  side [0:STAGES];
  logic signed [31:0] a0;
  logic signed [31:0] a1;
  logic               big;

  // fold angles beyond +-pi/2 by pi and negate at the end
  always_comb begin
    a0  = $signed({angle, 16'h0000});
    big = (a0 > 32'sh40000000) || (a0 < -32'sh40000000);
    a1  = big ? (a0 + 32'sh80000000) : a0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
    if (adv) begin
      x[0] <= dtwb_pkg::CORDIC_GAIN;
      y[0] <= '0;
      z[0] <= 34'(a1);
      flip[0] <= big;
      side[0] <= in_side;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
      if (adv) begin
        if (!z[i][33]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - dtwb_pkg::atan_turn(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + dtwb_pkg::atan_turn(i);
        end
        flip[i+1] <= flip[i];
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign cos_q30   = flip[STAGES] ? -x[STAGES][31:0] : x[STAGES][31:0];
  assign sin_q30   = flip[STAGES] ? -y[STAGES][31:0] : y[STAGES][31:0];
  assign out_side  = side[STAGES];

endmodule

// ----- design/detection_to_world_box.sv -----
// Top level: detection filter, polar to cartesian, rigid transform to frame.
// Path: bearing CORDIC, stages P1 and P2, yaw CORDIC, stages R1 and R2, output register.
// Throughput: one detection per cycle; whole pipeline advances together and
// freezes only when the output register is full and not taken.
// Dropped detections travel as bubbles and produce no result transfer.
// Reset (rst, synchronous): clears all valid bits and the configuration registers to 0.
module detection_to_world_box #(
  parameter int NUM_CLASSES   = 8,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         class_id,
  input  logic [7:0]         score,
  input  logic signed [31:0] range_dist,
  input  logic signed [15:0] bearing,
  input  logic signed [31:0] obj_height,
  input  logic signed [31:0] obj_width,
  input  logic signed [31:0] robot_x,
  input  logic signed [31:0] robot_y,
  input  logic signed [15:0] robot_yaw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] center_x,
  output logic signed [31:0] center_y,
  output logic [30:0]        size_x,
  output logic [30:0]        size_y
);

  localparam int SIDE_W = $bits(dtwb_pkg::side_t);
  localparam int B_W    = SIDE_W + 32 + 16 + 32; // side, range, yaw, half height

  // configuration registers
  logic signed [31:0] ofs_x, ofs_y;
  logic [1:0]         frame_mode;
  logic               mirror;
  logic [7:0]         en_mask;
  logic [63:0]        thresh;
  logic [2:0]         reg_idx;
  logic               wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ofs_x <= '0; ofs_y <= '0; frame_mode <= '0;
      mirror <= 1'b0; en_mask <= '0; thresh <= '0;
    end else if (wr) begin
      case (reg_idx)
        dtwb_pkg::REG_OFS_X:  ofs_x      <= pwdata[31:0];
        dtwb_pkg::REG_OFS_Y:  ofs_y      <= pwdata[31:0];
        dtwb_pkg::REG_MODE:   frame_mode <= pwdata[1:0];
        dtwb_pkg::REG_MIRROR: mirror     <= pwdata[0];
        dtwb_pkg::REG_ENABLE: en_mask    <= pwdata[7:0];
        dtwb_pkg::REG_THRESH: thresh     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dtwb_pkg::REG_OFS_X:  prdata = {32'h0, ofs_x};
      dtwb_pkg::REG_OFS_Y:  prdata = {32'h0, ofs_y};
      dtwb_pkg::REG_MODE:   prdata = {62'h0, frame_mode};
      dtwb_pkg::REG_MIRROR: prdata = {63'h0, mirror};
      dtwb_pkg::REG_ENABLE: prdata = {56'h0, en_mask};
      dtwb_pkg::REG_THRESH: prdata = thresh;
      default:              prdata = '0;
    endcase
  end

  // global advance: the whole pipe moves unless the output holds a result that is not taken
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 0: filter and angle prep
  logic               pass;
  logic [15:0]        bear_m;
  logic               cls_ok;
  always_comb begin
    cls_ok = (32'(class_id) < NUM_CLASSES) && (class_id < 8'd8);
    pass   = cls_ok && en_mask[class_id[2:0]]
          && (score >= thresh[{class_id[2:0], 3'b000} +: 8])
          && !obj_height[31] && !obj_width[31];
    bear_m = mirror ? (16'h0 - bearing) : bearing;
  end

  dtwb_pkg::side_t    s_in;
  logic [B_W-1:0]     b_in, b_out;
  always_comb begin
    s_in.mode_map  = (frame_mode == dtwb_pkg::MODE_MAP);
    s_in.mode_base = (frame_mode == dtwb_pkg::MODE_BASE);
    s_in.rob_x     = robot_x;
    s_in.rob_y     = robot_y;
    s_in.size_x    = obj_height[30:0];
    s_in.size_y    = obj_width[30:0];
    b_in = {s_in, range_dist, robot_yaw, obj_height >>> 1};
  end

  logic               b_vld;
  logic signed [31:0] cb, sb;
  dtwb_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(B_W)) u_bear (
    .clk, .rst, .adv,
    .in_valid(in_valid && pass), .angle(bear_m), .in_side(b_in),
    .out_valid(b_vld), .cos_q30(cb), .sin_q30(sb), .out_side(b_out)
  );

  // stage P1: range products
  dtwb_pkg::side_t    s1;
  logic               v1;
  logic signed [63:0] pcx, pcy;
  logic signed [31:0] hh1;
  logic [15:0]        yaw1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= b_vld;
    if (adv) begin
      s1   <= b_out[B_W-1 -: SIDE_W];
      pcx  <= $signed(b_out[79:48]) * cb;
      pcy  <= $signed(b_out[79:48]) * sb;
      yaw1 <= b_out[47:32];
      hh1  <= b_out[31:0];
    end
  end

  // stage P2: round, add half height and offset
  dtwb_pkg::side_t    s2;
  logic               v2;
  logic signed [31:0] px2, py2;
  logic signed [63:0] rx, ry;
  logic [15:0]        yaw2;
  always_comb begin
    rx = (pcx + 64'sd536870912) >>> 30;
    ry = (pcy + 64'sd536870912) >>> 30;
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      s2   <= s1;
      px2  <= rx[31:0] + hh1 + ofs_x;
      py2  <= ry[31:0] + ofs_y;
      yaw2 <= yaw1;
    end
  end

  // yaw CORDIC carries the sensor-frame point along
  localparam int Y_W = SIDE_W + 64;
  logic [Y_W-1:0]     y_out;
  logic               y_vld;
  logic signed [31:0] cy, sy;
  dtwb_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(Y_W)) u_yaw (
    .clk, .rst, .adv,
    .in_valid(v2), .angle(yaw2), .in_side({s2, px2, py2}),
    .out_valid(y_vld), .cos_q30(cy), .sin_q30(sy), .out_side(y_out)
  );

  // stage R1: four products
  dtwb_pkg::side_t    s3;
  logic               v3;
  logic signed [63:0] m_xc, m_ys, m_xs, m_yc;
  logic signed [31:0] px3, py3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= y_vld;
    if (adv) begin
      s3   <= y_out[Y_W-1 -: SIDE_W];
      px3  <= y_out[63:32];
      py3  <= y_out[31:0];
      m_xc <= $signed(y_out[63:32]) * cy;
      m_ys <= $signed(y_out[31:0]) * sy;
      m_xs <= $signed(y_out[63:32]) * sy;
      m_yc <= $signed(y_out[31:0]) * cy;
    end
  end

  // stage R2: sum products
  dtwb_pkg::side_t    s4;
  logic               v4;
  logic signed [63:0] sx4, sy4;
  logic signed [31:0] px4, py4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      s4  <= s3;
      px4 <= px3;
      py4 <= py3;
      sx4 <= m_xc - m_ys + 64'sd536870912;
      sy4 <= m_xs + m_yc + 64'sd536870912;
    end
  end

  // output register: round, shift by robot position, pick frame
  logic signed [63:0] fx, fy;
  always_comb begin
    fx = sx4 >>> 30;
    fy = sy4 >>> 30;
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v4;
    if (adv) begin
      size_x <= s4.size_x;
      size_y <= s4.size_y;
      if (s4.mode_map) begin
        center_x <= fx[31:0] + s4.rob_x;
        center_y <= fy[31:0] + s4.rob_y;
      end else if (s4.mode_base) begin
        center_x <= px4;
        center_y <= py4;
      end else begin
        center_x <= '0;
        center_y <= '0;
      end
    end
  end

endmodule
